[rtl/srrw_pkg.sv]
// shared types and constants of the selective repeat receive window
package srrw_pkg;

	// field widths
	localparam int SEQ_W      = 16;
	localparam int LEN_W      = 11;
	localparam int WS_W       = 6;
	localparam int BF_W       = 17;
	localparam int NE_W       = 17;
	localparam int OFFS_W     = 26;
	localparam int FBYTES_W   = 27;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// framing constants
	localparam int SEQ_BITS         = 16;
	localparam int FRAME_DATA_BYTES = 1024;
	localparam int FDB_W            = 17;
	localparam int PROD_W           = SEQ_W + FDB_W;
	localparam int WINDOW_MAX_DEF   = 32;

	localparam logic [SEQ_W-1:0] SEQ_MASK = (SEQ_BITS >= SEQ_W) ? {SEQ_W{1'b1}} :
		SEQ_W'((64'd1 << SEQ_BITS) - 64'd1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_FRAMES = 2'd1;

	// register reset values
	localparam logic [WS_W-1:0] RST_WINDOW_SIZE   = 6'd8;
	localparam logic [BF_W-1:0] RST_BUFFER_FRAMES = 17'd16;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic apply;
	} srrw_cmd_t;

endpackage

[rtl/srrw_ctrl.sv]
// controller: frame handshake, apply sequencing and ack valid
module srrw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	output logic              ack_valid,
	input  logic              ack_stall,
	output srrw_pkg::srrw_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   ack_valid_q;
	logic   accept;
	logic   out_free;

	assign frame_stall = (state_q != ST_IDLE);
	assign accept      = frame_valid && !frame_stall;
	assign out_free    = !ack_valid_q || !ack_stall;

	assign cmd.capture = accept;
	assign cmd.apply   = (state_q == ST_APPLY) && out_free;
	assign ack_valid   = ack_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ack_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.apply) begin
				ack_valid_q <= 1'b1;
			end else if (!ack_stall) begin
				ack_valid_q <= 1'b0;
			end
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_APPLY) && frame_stall)
		else $error("no apply phase after frame accept");

	a_apply_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> ack_valid_q)
		else $error("ack not presented after apply");

	a_apply_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_APPLY) && !ack_valid_q) |=> (state_q == ST_IDLE))
		else $error("apply stuck with free output register");

endmodule

[rtl/srrw_datapath.sv]
// datapath: window state, slide count, mask shift and ack registers
module srrw_datapath #(
	parameter int WINDOW_MAX = srrw_pkg::WINDOW_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srrw_pkg::srrw_cmd_t             cmd,
	input  logic                            cfg_we,
	input  logic [srrw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srrw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [srrw_pkg::SEQ_W-1:0]      seq_number,
	input  logic                            frame_bad,
	input  logic                            end_flag,
	input  logic [srrw_pkg::LEN_W-1:0]      payload_length,
	output logic [srrw_pkg::SEQ_W-1:0]      ack_seq,
	output logic                            ack_bad,
	output logic                            store_payload,
	output logic [srrw_pkg::OFFS_W-1:0]     store_offset,
	output logic                            buffer_done,
	output logic                            transfer_done,
	output logic [srrw_pkg::FBYTES_W-1:0]   final_bytes
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int WCW   = (CNT_W > srrw_pkg::WS_W) ? CNT_W : srrw_pkg::WS_W;
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUM_W = srrw_pkg::NE_W + 1;

	// configuration and window state
	logic [srrw_pkg::WS_W-1:0] window_size_q;
	logic [srrw_pkg::BF_W-1:0] buffer_frames_q;
	logic [srrw_pkg::NE_W-1:0] ne_q;
	logic [WINDOW_MAX-1:0]     mask_q;
	logic [srrw_pkg::NE_W-1:0] limit_q;
	logic                      end_seen_q;
	logic                      finished_q;

	// captured frame
	logic [srrw_pkg::SEQ_W-1:0]  seq_s1;
	logic                        bad_s1;
	logic                        end_s1;
	logic [srrw_pkg::LEN_W-1:0]  len_s1;
	logic [srrw_pkg::PROD_W-1:0] prod_s1;
	logic                        in_win_s1;
	logic                        hit_s1;
	logic                        later_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [CNT_W-1:0]            shift_s1;

	// ack registers
	logic [srrw_pkg::SEQ_W-1:0]    ack_seq_q;
	logic                          ack_bad_q;
	logic                          store_q;
	logic [srrw_pkg::OFFS_W-1:0]   offset_q;
	logic                          bdone_q;
	logic                          tdone_q;
	logic [srrw_pkg::FBYTES_W-1:0] fbytes_q;

	// capture side
	logic [srrw_pkg::SEQ_W-1:0] seq_m;
	logic [WCW-1:0]             ws_ext;
	logic [WCW-1:0]             weff;
	logic [SUM_W-1:0]           win_end;
	logic [WINDOW_MAX:0]        run_v;
	logic [WINDOW_MAX:0]        first_zero;
	logic [CNT_W-1:0]           shift_c;
	logic [srrw_pkg::NE_W-1:0]  seq_diff;

	assign seq_m   = seq_number & srrw_pkg::SEQ_MASK;
	assign ws_ext  = WCW'(window_size_q);
	assign win_end = SUM_W'(ne_q) + SUM_W'(weff);
	assign seq_diff = srrw_pkg::NE_W'(seq_m) - ne_q;

	always_comb begin
		if (window_size_q == '0) begin
			weff = WCW'(1);
		end else if (ws_ext > WCW'(WINDOW_MAX)) begin
			weff = WCW'(WINDOW_MAX);
		end else begin
			weff = ws_ext;
		end
	end

	// run of arrived frames right after next_expected: first zero via add carry
	always_comb begin
		run_v             = '0;
		run_v[0]          = 1'b1;
		for (int i = 1; i < WINDOW_MAX; i++) begin
			run_v[i] = mask_q[i] && (WCW'(i) < weff);
		end
		first_zero = ~run_v & (run_v + 1'b1);
		shift_c    = '0;
		for (int i = 0; i <= WINDOW_MAX; i++) begin
			shift_c = shift_c | (first_zero[i] ? CNT_W'(i) : CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_s1    <= seq_m;
			bad_s1    <= frame_bad;
			end_s1    <= end_flag;
			len_s1    <= payload_length;
			prod_s1   <= srrw_pkg::PROD_W'(seq_m) *
				srrw_pkg::PROD_W'(srrw_pkg::FRAME_DATA_BYTES);
			in_win_s1 <= SUM_W'(seq_m) < win_end;
			hit_s1    <= srrw_pkg::NE_W'(seq_m) == ne_q;
			later_s1  <= srrw_pkg::NE_W'(seq_m) > ne_q;
			idx_s1    <= IDX_W'(seq_diff);
			shift_s1  <= shift_c;
		end
	end

	// apply side
	logic                          in_ok;
	logic                          later_new;
	logic                          store_c;
	logic                          end_hit;
	logic                          end_seen_c;
	logic                          bdone_c;
	logic                          tdone_c;
	logic [WINDOW_MAX-1:0]         mask_c;
	logic [srrw_pkg::NE_W-1:0]     ne_c;
	logic [srrw_pkg::NE_W-1:0]     limit_c;
	logic [srrw_pkg::FBYTES_W-1:0] fbytes_c;
	logic [srrw_pkg::OFFS_W-1:0]   offset_c;

	assign in_ok      = !finished_q && in_win_s1 && !bad_s1;
	assign later_new  = in_ok && later_s1 && !mask_q[idx_s1];
	assign store_c    = in_ok && (hit_s1 || later_new);
	assign end_hit    = in_ok && end_s1;
	assign end_seen_c = end_seen_q || end_hit;
	assign ne_c       = (in_ok && hit_s1) ? ne_q + srrw_pkg::NE_W'(shift_s1) : ne_q;
	assign limit_c    = end_hit ? srrw_pkg::NE_W'(seq_s1) + srrw_pkg::NE_W'(1) : limit_q;
	assign bdone_c    = !finished_q && (ne_c >= limit_c);
	assign tdone_c    = bdone_c && end_seen_c;
	assign offset_c   = store_c ? srrw_pkg::OFFS_W'(prod_s1) : '0;
	assign fbytes_c   = end_hit ?
		srrw_pkg::FBYTES_W'(prod_s1 + srrw_pkg::PROD_W'(len_s1)) : '0;

	always_comb begin
		mask_c = mask_q;
		if (in_ok && hit_s1) begin
			mask_c = mask_q >> shift_s1;
		end else if (later_new) begin
			mask_c[idx_s1] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= srrw_pkg::RST_WINDOW_SIZE;
			buffer_frames_q <= srrw_pkg::RST_BUFFER_FRAMES;
			ne_q            <= '0;
			mask_q          <= '0;
			limit_q         <= srrw_pkg::NE_W'(srrw_pkg::RST_BUFFER_FRAMES);
			end_seen_q      <= 1'b0;
			finished_q      <= 1'b0;
		end else begin
			if (cmd.apply) begin
				end_seen_q <= end_seen_c;
				if (tdone_c) begin
					finished_q <= 1'b1;
				end
				if (bdone_c && !end_seen_c) begin
					ne_q    <= '0;
					mask_q  <= '0;
					limit_q <= srrw_pkg::NE_W'(buffer_frames_q);
				end else begin
					ne_q    <= ne_c;
					mask_q  <= mask_c;
					limit_q <= limit_c;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					srrw_pkg::REG_WINDOW_SIZE: begin
						window_size_q <= cfg_data[srrw_pkg::WS_W-1:0];
					end
					srrw_pkg::REG_BUFFER_FRAMES: begin
						buffer_frames_q <= cfg_data[srrw_pkg::BF_W-1:0];
						if (!end_seen_q) begin
							limit_q <= srrw_pkg::NE_W'(cfg_data[srrw_pkg::BF_W-1:0]);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			ack_seq_q <= seq_s1;
			ack_bad_q <= bad_s1;
			store_q   <= store_c;
			offset_q  <= offset_c;
			bdone_q   <= bdone_c;
			tdone_q   <= tdone_c;
			fbytes_q  <= fbytes_c;
		end
	end

	assign ack_seq       = ack_seq_q;
	assign ack_bad       = ack_bad_q;
	assign store_payload = store_q;
	assign store_offset  = offset_q;
	assign buffer_done   = bdone_q;
	assign transfer_done = tdone_q;
	assign final_bytes   = fbytes_q;

	a_no_store_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && !store_c) |=> (store_offset == '0))
		else $error("offset reported without store");

	a_new_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && bdone_c && !end_seen_c) |=> ((ne_q == '0) && (mask_q == '0)))
		else $error("window not restarted on buffer completion");

	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag dropped");

	a_done_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && tdone_c) |=> (finished_q && transfer_done && buffer_done))
		else $error("transfer done without finish");

endmodule

[rtl/selective_repeat_receive_window.sv]
// top level of the selective repeat receive window
//
// frame channel: one parsed frame header per word (seq_number, frame_bad,
// end_flag, payload_length), taken when frame_valid is high and frame_stall low
// ack channel: one ack word per frame (ack_seq, ack_bad, store_payload,
// store_offset, buffer_done, transfer_done, final_bytes), taken when ack_valid
// is high and ack_stall low
// config port: cfg_we with cfg_index 0 writes window_size, 1 writes
// buffer_frames; other indexes are dropped; write only while no frame is open
// latency: the ack word is valid one cycle after the frame edge, so it can be
// taken at the second edge after the frame edge at the earliest
// throughput: one frame every 2 cycles; the slide count over the arrival mask
// is taken on the accept edge and the mask shift plus window update on the next
// frame_stall is high for the one update cycle, and stays high while the ack
// register still holds an untaken word at that point
// ack_stall only holds the ack register; one frame can be accepted while an ack
// waits
// reset: window empty, next expected frame 0, window_size 8, buffer_frames 16,
// no ack pending
module selective_repeat_receive_window #(
	parameter int WINDOW_MAX = srrw_pkg::WINDOW_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config
	input  logic                            cfg_we,
	input  logic [srrw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srrw_pkg::CFG_DATA_W-1:0] cfg_data,
	// frame channel
	input  logic                            frame_valid,
	output logic                            frame_stall,
	input  logic [srrw_pkg::SEQ_W-1:0]      seq_number,
	input  logic                            frame_bad,
	input  logic                            end_flag,
	input  logic [srrw_pkg::LEN_W-1:0]      payload_length,
	// ack channel
	output logic                            ack_valid,
	input  logic                            ack_stall,
	output logic [srrw_pkg::SEQ_W-1:0]      ack_seq,
	output logic                            ack_bad,
	output logic                            store_payload,
	output logic [srrw_pkg::OFFS_W-1:0]     store_offset,
	output logic                            buffer_done,
	output logic                            transfer_done,
	output logic [srrw_pkg::FBYTES_W-1:0]   final_bytes
);

	// capture / apply strobes from the controller
	srrw_pkg::srrw_cmd_t cmd;

	srrw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.ack_valid   (ack_valid),
		.ack_stall   (ack_stall),
		.cmd         (cmd)
	);

	// window state, slide logic and ack word registers
	srrw_datapath #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.seq_number     (seq_number),
		.frame_bad      (frame_bad),
		.end_flag       (end_flag),
		.payload_length (payload_length),
		.ack_seq        (ack_seq),
		.ack_bad        (ack_bad),
		.store_payload  (store_payload),
		.store_offset   (store_offset),
		.buffer_done    (buffer_done),
		.transfer_done  (transfer_done),
		.final_bytes    (final_bytes)
	);

endmodule
